// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MaxResults = 4;
    localparam int CountWidth = $clog2(MaxResults + 1);
    localparam int IndexWidth = $clog2(MaxResults);

    // Result kinds as they appear on the output port.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6e;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_result;

    // All results caused by one text byte, oldest in entry zero.
    typedef struct packed {
        t_result [MaxResults-1:0] item;
        logic [CountWidth-1:0]    count;
    } t_bundle;

endpackage

// ===== hdl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and the decode of one text byte into its bundle of results.
// ----------------------------------------------------------------------------
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_advance,
    output t_bundle    o_bundle
);

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_ESCAPE = 2'd2,
        MODE_HEX    = 2'd3
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_point, n_code_point;

    logic [3:0]  hex_digit;
    logic        hex_ok;
    logic [15:0] cp_next;
    t_bundle     bundle;

    always_comb begin
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (i_text_byte >= 8'h30 && i_text_byte <= 8'h39) begin
            hex_digit = i_text_byte[3:0];
        end else if ((i_text_byte >= 8'h61 && i_text_byte <= 8'h66) ||
                     (i_text_byte >= 8'h41 && i_text_byte <= 8'h46)) begin
            hex_digit = i_text_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cp_next = {r_code_point[11:0], hex_digit};

    always_comb begin
        n_mode       = r_mode;
        n_hex_count  = r_hex_count;
        n_code_point = r_code_point;
        bundle       = '0;

        unique case (r_mode)
            MODE_IDLE: begin
                if (i_text_byte != CHAR_QUOTE) begin
                    bundle.item[0] = '{kind: KIND_ERROR, data: 8'h00};
                    bundle.count   = CountWidth'(1);
                end else begin
                    n_mode = MODE_STRING;
                end
            end
            MODE_STRING: begin
                if (i_text_byte == CHAR_QUOTE) begin
                    bundle.item[0] = '{kind: KIND_DONE, data: 8'h00};
                    bundle.count   = CountWidth'(1);
                    n_mode         = MODE_IDLE;
                end else if (i_text_byte == CHAR_BACKSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    bundle.item[0] = '{kind: KIND_BYTE, data: i_text_byte};
                    bundle.count   = CountWidth'(1);
                end
            end
            MODE_ESCAPE: begin
                n_mode         = MODE_STRING;
                bundle.count   = CountWidth'(1);
                bundle.item[0] = '{kind: KIND_BYTE, data: i_text_byte};
                unique case (i_text_byte)
                    CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: ;
                    CHAR_B: bundle.item[0].data = 8'h08;
                    CHAR_F: bundle.item[0].data = 8'h0c;
                    CHAR_N: bundle.item[0].data = 8'h0a;
                    CHAR_R: bundle.item[0].data = 8'h0d;
                    CHAR_T: bundle.item[0].data = 8'h09;
                    CHAR_U: begin
                        bundle.count = '0;
                        n_mode       = MODE_HEX;
                        n_hex_count  = 2'd0;
                        n_code_point = 16'h0000;
                    end
                    default: begin
                        bundle.item[0] = '{kind: KIND_ERROR, data: 8'h00};
                        n_mode         = MODE_IDLE;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!hex_ok) begin
                    bundle.item[0] = '{kind: KIND_ERROR, data: 8'h00};
                    bundle.count   = CountWidth'(1);
                    n_mode         = MODE_IDLE;
                end else begin
                    n_code_point = cp_next;
                    if (r_hex_count == 2'd3) begin
                        n_hex_count = 2'd0;
                        n_mode      = MODE_STRING;
                        // Encode the gathered code point as UTF-8.
                        if (cp_next[15:7] == '0) begin
                            bundle.item[0] = '{kind: KIND_BYTE, data: cp_next[7:0]};
                            bundle.count   = CountWidth'(1);
                        end else if (cp_next[15:11] == '0) begin
                            bundle.item[0] = '{kind: KIND_BYTE,
                                               data: {3'b110, cp_next[10:6]}};
                            bundle.item[1] = '{kind: KIND_BYTE,
                                               data: {2'b10, cp_next[5:0]}};
                            bundle.count   = CountWidth'(2);
                        end else begin
                            bundle.item[0] = '{kind: KIND_BYTE,
                                               data: {4'b1110, cp_next[15:12]}};
                            bundle.item[1] = '{kind: KIND_BYTE,
                                               data: {2'b10, cp_next[11:6]}};
                            bundle.item[2] = '{kind: KIND_BYTE,
                                               data: {2'b10, cp_next[5:0]}};
                            bundle.count   = CountWidth'(3);
                        end
                    end else begin
                        n_hex_count = r_hex_count + 2'd1;
                    end
                end
            end
            default: n_mode = MODE_IDLE;
        endcase

        // Text that runs out inside a string closes with an error after
        // whatever this byte has already produced.
        if (i_end_of_text && n_mode != MODE_IDLE) begin
            bundle.item[bundle.count[IndexWidth-1:0]] = '{kind: KIND_ERROR, data: 8'h00};
            bundle.count = bundle.count + CountWidth'(1);
            n_mode       = MODE_IDLE;
        end
    end

    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_hex_count  <= 2'd0;
            r_code_point <= 16'h0000;
        end else if (i_advance) begin
            r_mode       <= n_mode;
            r_hex_count  <= n_hex_count;
            r_code_point <= n_code_point;
        end
    end

endmodule

// ===== hdl/jsu_out_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_out_queue
// Result register holding one bundle and handing out its entries in order.
// ----------------------------------------------------------------------------
module jsu_out_queue
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bundle    i_bundle,
    input  logic       i_load,
    output logic       o_can_load,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    t_result [MaxResults-1:0] r_item, n_item;
    logic [CountWidth-1:0]    r_left, n_left;
    logic                     fire;

    assign fire        = o_out_valid && i_out_ready;
    assign o_out_valid = (r_left != '0);
    assign o_can_load  = (r_left == '0) || (r_left == CountWidth'(1) && i_out_ready);
    assign o_kind      = r_item[0].kind;
    assign o_out_byte  = r_item[0].data;
    assign o_run_last  = (r_left == CountWidth'(1));

    always_comb begin
        n_item = r_item;
        n_left = r_left;
        if (fire) begin
            // Move the remaining results down one place.
            for (int i = 0; i < MaxResults - 1; i++) begin
                n_item[i] = r_item[i+1];
            end
            n_left = r_left - CountWidth'(1);
        end
        if (i_load) begin
            n_item = i_bundle.item;
            n_left = i_bundle.count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

    a_load_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_left == '0 || (r_left == CountWidth'(1) && fire)))
        else $error("bundle loaded over undelivered results");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_left > CountWidth'(1)) |=> o_out_valid)
        else $error("bundle dropped results after a transaction");

    a_status_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_BYTE) |-> (o_run_last && o_out_byte == 8'h00))
        else $error("done or error result is not the last of its run");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CountWidth'(MaxResults))
        else $error("result count beyond the bundle size");

endmodule

// ===== hdl/json_string_unescape.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes one quoted JSON string literal from a byte stream into UTF-8 bytes.
// ----------------------------------------------------------------------------
// One text byte is taken per clock while each byte yields at most one result and
// the receiver stays ready; a byte that yields n results (a \u escape encoding to
// two or three UTF-8 bytes, or an end-of-text error appended to them) holds the
// output side until all n, up to four, are taken; the input side stalls only
// for the extra ones. A byte's first result is presented once it has passed
// from the input register through the decoder into the result register, which
// it enters once earlier results are all taken or their last is being taken.
// Every byte that produces results returns them as one run; the last carries
// run_last, and a byte that produces nothing leaves no trace on the output.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;

    t_bundle    bundle;
    logic       can_load;
    logic       advance;
    logic       load;

    // A byte with no results never needs the result register.
    assign advance    = r_in_valid && (bundle.count == '0 || can_load);
    assign load       = advance && (bundle.count != '0);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    jsu_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_byte   (r_in_byte),
        .i_end_of_text (r_in_eot),
        .i_advance     (advance),
        .o_bundle      (bundle)
    );

    jsu_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bundle    (bundle),
        .i_load      (load),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last)
    );

endmodule

// ===== dv/tb_json_string_unescape.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape
// Self-checking bench for the JSON string unescaper. A short table of text
// bytes covers the extremes and the fault cases. Random string literals follow,
// most of them well formed and some deliberately broken. Every accepted byte is
// run through a local decoder, and the results are compared in order.
// ----------------------------------------------------------------------------
module tb_json_string_unescape;
    import jsu_pkg::*;

    localparam int NumDirected   = 27;
    localparam int RandomItems   = 250;
    localparam int MaxGap        = 40;
    localparam int HoldOffCycles = 80;
    localparam int DrainCycles   = 20;
    localparam int CycleLimit    = 400000;

    // Characters used by the stimulus beyond those in the package.
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_G = 8'h67;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    // Control bytes produced by the single-letter escapes.
    localparam logic [7:0] CTRL_BACKSPACE = 8'h08;
    localparam logic [7:0] CTRL_TAB       = 8'h09;
    localparam logic [7:0] CTRL_NEWLINE   = 8'h0a;
    localparam logic [7:0] CTRL_FORMFEED  = 8'h0c;
    localparam logic [7:0] CTRL_RETURN    = 8'h0d;

    localparam logic [7:0] EscapeChars [8] = '{CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH,
                                               CHAR_B, CHAR_F, CHAR_N, CHAR_R, CHAR_T};
    localparam logic [15:0] EdgeCodePoints [6] = '{16'h0000, 16'h007f, 16'h0080,
                                                   16'h07ff, 16'h0800, 16'hffff};

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_ESCAPE,
        MODE_HEX
    } t_parse_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_expect;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       typed;       // outcome written in the table below
        logic       has_result;
        logic [1:0] kind;
        logic [7:0] data;
    } t_text_row;

    localparam t_text_row DirectedText [NumDirected] = '{
        '{8'h00,          1'b0, 1'b1, 1'b1, KIND_ERROR, 8'h00},  // idle, not a quote
        '{8'hff,          1'b0, 1'b1, 1'b1, KIND_ERROR, 8'h00},
        '{CHAR_QUOTE,     1'b1, 1'b1, 1'b1, KIND_ERROR, 8'h00},  // quote is last byte
        '{CHAR_QUOTE,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{8'h00,          1'b0, 1'b1, 1'b1, KIND_BYTE,  8'h00},
        '{8'hff,          1'b0, 1'b1, 1'b1, KIND_BYTE,  8'hff},
        '{CHAR_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_N,         1'b0, 1'b0, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_LOWER_X,     1'b0, 1'b1, 1'b1, KIND_ERROR, 8'h00},  // unknown escape
        '{CHAR_QUOTE,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_U,         1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_UPPER_F,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_LOWER_F,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_LOWER_F,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_UPPER_F,     1'b0, 1'b0, 1'b0, KIND_BYTE,  8'h00},  // three UTF-8 bytes
        '{CHAR_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_U,         1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_0,           1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_LOWER_G,     1'b0, 1'b1, 1'b1, KIND_ERROR, 8'h00},  // bad hex digit
        '{CHAR_QUOTE,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CHAR_QUOTE,     1'b1, 1'b0, 1'b0, KIND_BYTE,  8'h00},  // text ends in string
        '{CHAR_QUOTE,     1'b0, 1'b1, 1'b0, KIND_BYTE,  8'h00},
        '{CH_UPPER_A,     1'b0, 1'b1, 1'b1, KIND_BYTE,  CH_UPPER_A},
        '{CHAR_QUOTE,     1'b1, 1'b1, 1'b1, KIND_DONE,  8'h00}   // close on last byte
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [7:0] i_text_byte   = 8'h00;
    logic       i_end_of_text = 1'b0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    json_string_unescape dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last)
    );

    // Decoder state, mirrored from the block.
    t_parse_mode parse_mode  = MODE_IDLE;
    logic [1:0]  digit_count = 2'd0;
    logic [15:0] code_acc    = 16'h0000;
    t_expect     step_res [MaxResults];
    int          step_count;

    t_expect     decoded_q [$];
    t_text_row   offered_q [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    bit hold_off_req = 1'b0;
    int items_sent   = 0;
    int results_seen = 0;
    int closes_seen  = 0;
    int errors_seen  = 0;
    int failures     = 0;
    int cycle_count  = 0;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("%0t: timed out with %0d results outstanding", $time, decoded_q.size());
            $display("json_string_unescape verification failed");
            $finish;
        end
    end

    function automatic int hex_value(input logic [7:0] c);
        int v;
        v = -1;
        if (c >= CH_0 && c <= CH_9) v = int'(c - CH_0);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F) v = int'(c - CH_LOWER_A) + 10;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F) v = int'(c - CH_UPPER_A) + 10;
        return v;
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] data);
        step_res[step_count] = '{kind, data, 1'b0};
        step_count++;
    endfunction

    function automatic void abort_string();
        add_result(KIND_ERROR, 8'h00);
        parse_mode = MODE_IDLE;
    endfunction

    // Works out the results of one text byte and advances the decoder state.
    function automatic void unescape_byte(input logic [7:0] c, input logic eot);
        int d;
        step_count = 0;
        case (parse_mode)
            MODE_IDLE: begin
                if (c == CHAR_QUOTE) parse_mode = MODE_STRING;
                else abort_string();
            end
            MODE_STRING: begin
                if (c == CHAR_QUOTE) begin
                    add_result(KIND_DONE, 8'h00);
                    parse_mode = MODE_IDLE;
                end else if (c == CHAR_BACKSLASH) begin
                    parse_mode = MODE_ESCAPE;
                end else begin
                    add_result(KIND_BYTE, c);
                end
            end
            MODE_ESCAPE: begin
                parse_mode = MODE_STRING;
                case (c)
                    CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: add_result(KIND_BYTE, c);
                    CHAR_B: add_result(KIND_BYTE, CTRL_BACKSPACE);
                    CHAR_F: add_result(KIND_BYTE, CTRL_FORMFEED);
                    CHAR_N: add_result(KIND_BYTE, CTRL_NEWLINE);
                    CHAR_R: add_result(KIND_BYTE, CTRL_RETURN);
                    CHAR_T: add_result(KIND_BYTE, CTRL_TAB);
                    CHAR_U: begin
                        parse_mode  = MODE_HEX;
                        digit_count = 2'd0;
                        code_acc    = 16'h0000;
                    end
                    default: abort_string();
                endcase
            end
            default: begin
                d = hex_value(c);
                if (d < 0) begin
                    abort_string();
                end else begin
                    code_acc = {code_acc[11:0], d[3:0]};
                    if (digit_count == 2'd3) begin
                        digit_count = 2'd0;
                        parse_mode  = MODE_STRING;
                        if (code_acc <= 16'h007f) begin
                            add_result(KIND_BYTE, code_acc[7:0]);
                        end else if (code_acc <= 16'h07ff) begin
                            add_result(KIND_BYTE, {3'b110, code_acc[10:6]});
                            add_result(KIND_BYTE, {2'b10, code_acc[5:0]});
                        end else begin
                            add_result(KIND_BYTE, {4'b1110, code_acc[15:12]});
                            add_result(KIND_BYTE, {2'b10, code_acc[11:6]});
                            add_result(KIND_BYTE, {2'b10, code_acc[5:0]});
                        end
                    end else begin
                        digit_count = digit_count + 2'd1;
                    end
                end
            end
        endcase
        // Text that runs out inside a literal is reported after this byte's output.
        if (eot && parse_mode != MODE_IDLE) abort_string();
        if (step_count > 0) step_res[step_count-1].last = 1'b1;
    endfunction

    // Accepted text bytes are decoded here; accepted results are checked here.
    always @(posedge i_clk) begin
        t_text_row row;
        t_expect   want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                row = offered_q.pop_front();
                unescape_byte(i_text_byte, i_end_of_text);
                if (row.typed) begin
                    if (row.has_result) begin
                        decoded_q.insert(decoded_q.size(),
                                         t_expect'{row.kind, row.data, 1'b1});
                    end
                end else begin
                    for (int k = 0; k < step_count; k++) begin
                        decoded_q.insert(decoded_q.size(), step_res[k]);
                    end
                end
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_kind == KIND_DONE) closes_seen++;
                if (o_kind == KIND_ERROR) errors_seen++;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d, byte %02h, run_last %0b",
                             $time, o_kind, o_out_byte, o_run_last);
                    failures++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_kind !== want.kind) begin
                        $display("%0t: kind mismatch: expected %0d, got %0d",
                                 $time, want.kind, o_kind);
                        failures++;
                    end
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %02h, got %02h",
                                 $time, want.data, o_out_byte);
                        failures++;
                    end
                    if (o_run_last !== want.last) begin
                        $display("%0t: run_last mismatch: expected %0b, got %0b",
                                 $time, want.last, o_run_last);
                        failures++;
                    end
                end
            end
        end
    end

    // Receiver side: random stalls, and one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HoldOffCycles) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_byte(input t_text_row row);
        int gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(0, 99) < idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_q.insert(offered_q.size(), row);
        i_in_valid    <= 1'b1;
        i_text_byte   <= row.ch;
        i_end_of_text <= row.eot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10) c = CH_0 + v;
        else if ($urandom_range(0, 1) != 0) c = CH_LOWER_A + (v - 4'd10);
        else c = CH_UPPER_A + (v - 4'd10);
        return c;
    endfunction

    function automatic logic [15:0] random_code_point();
        logic [15:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 16'($urandom_range(0, 16'h007f));
            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
            2: cp = 16'($urandom_range(16'h0800, 16'hffff));
            default: cp = EdgeCodePoints[$urandom_range(0, 5)];
        endcase
        return cp;
    endfunction

    function automatic bit is_escape_char(input logic [7:0] c);
        bit hit;
        hit = (c == CHAR_U);
        foreach (EscapeChars[k]) if (c == EscapeChars[k]) hit = 1'b1;
        return hit;
    endfunction

    // One random literal: mostly well formed, otherwise truncated, preceded by
    // stray text, or broken by a bad escape or a bad hex digit.
    task automatic send_literal();
        logic [7:0]  lit [$];
        logic [7:0]  b;
        logic [15:0] cp;
        t_text_row   row;
        int          shape;
        int          cut;
        int          eot_at;
        shape  = $urandom_range(0, 99);
        eot_at = -1;
        lit.insert(lit.size(), CHAR_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 2))
                0: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CHAR_QUOTE || b == CHAR_BACKSLASH);
                    lit.insert(lit.size(), b);
                end
                1: begin
                    lit.insert(lit.size(), CHAR_BACKSLASH);
                    lit.insert(lit.size(), EscapeChars[$urandom_range(0, 7)]);
                end
                default: begin
                    cp = random_code_point();
                    lit.insert(lit.size(), CHAR_BACKSLASH);
                    lit.insert(lit.size(), CHAR_U);
                    for (int k = 3; k >= 0; k--) begin
                        lit.insert(lit.size(), hex_char(cp[k*4 +: 4]));
                    end
                end
            endcase
        end
        if (shape < 86) begin
            lit.insert(lit.size(), CHAR_QUOTE);
            if (shape >= 72 && shape < 80) eot_at = $urandom_range(0, lit.size() - 2);
            else if ($urandom_range(0, 3) == 0) eot_at = lit.size() - 1;
            if (shape >= 80) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CHAR_QUOTE);
                lit.push_front(b);
            end
        end else if (shape < 93) begin
            lit.insert(lit.size(), CHAR_BACKSLASH);
            do b = 8'($urandom_range(0, 255));
            while (is_escape_char(b));
            lit.insert(lit.size(), b);
        end else begin
            lit.insert(lit.size(), CHAR_BACKSLASH);
            lit.insert(lit.size(), CHAR_U);
            repeat ($urandom_range(0, 3)) begin
                lit.insert(lit.size(), hex_char(4'($urandom_range(0, 15))));
            end
            do b = 8'($urandom_range(0, 255));
            while (hex_value(b) >= 0);
            lit.insert(lit.size(), b);
        end
        cut = (eot_at >= 0) ? eot_at : lit.size() - 1;
        for (int k = 0; k <= cut; k++) begin
            row     = '0;
            row.ch  = lit[k];
            row.eot = (k == eot_at);
            send_byte(row);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DirectedText[k]) send_byte(DirectedText[k]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct     = 0;
                    stall_pct    = 0;
                    hold_off_req = 1'b1;
                end
                1: begin
                    idle_pct  = 84;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 84;
                end
                default: begin
                    idle_pct  = 8;
                    stall_pct = 8;
                end
            endcase
            while (items_sent < NumDirected + (phase + 1) * RandomItems / 4) send_literal();
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Fed %0d text bytes (%0d from the table) and checked %0d results,",
                 items_sent, NumDirected, results_seen);
        $display("among them %0d closed strings and %0d error reports.",
                 closes_seen, errors_seen);
        if (failures == 0) begin
            $display("json_string_unescape verification clean");
        end else begin
            $display("json_string_unescape verification failed");
        end
        $finish;
    end

endmodule
